// File: src/nsd_pkg.sv
// ---------------------------------------------------------------------------
// nsd_pkg: shared types and constants of the 2x2 neighbor-select downscaler
// Widths, register indexes, the block record passed from front to back, and
// the clamp and select functions.
// ---------------------------------------------------------------------------
package nsd_pkg;

  localparam int MAX_LINE_WIDTH = 1024;
  localparam int PIX_W          = 8;
  localparam int LW_W           = 11;
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
  localparam int WW             = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;
  localparam int BANK_DEPTH     = MAX_LINE_WIDTH / 2;
  localparam int BANK_AW        = COL_W - 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = LW_W;

  localparam logic [LW_W-1:0]  LINE_WIDTH_RST = LW_W'(720);
  localparam logic [PIX_W-1:0] CLAMP_LOW_RST  = PIX_W'(16);
  localparam logic [PIX_W-1:0] CLAMP_HIGH_RST = PIX_W'(240);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LINE_WIDTH = 2'd0,
    REG_CLAMP_LOW  = 2'd1,
    REG_CLAMP_HIGH = 2'd2
  } reg_idx_t;

  // one 2x2 block, ready for selection
  typedef struct packed {
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] br;
    logic             last;
  } quad_t;

  function automatic logic [PIX_W-1:0] clamp_pix(input logic [PIX_W-1:0] v,
                                                 input logic [PIX_W-1:0] lo,
                                                 input logic [PIX_W-1:0] hi);
    logic [PIX_W-1:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] choose_pix(input logic [PIX_W-1:0] bl,
                                                  input logic [PIX_W-1:0] br,
                                                  input logic [PIX_W-1:0] tr,
                                                  input logic [PIX_W-1:0] tl);
    logic [PIX_W:0]   s_brtr;
    logic [PIX_W:0]   s_trtl;
    logic [PIX_W:0]   s_tlbr;
    logic [PIX_W+1:0] s_all;
    logic [PIX_W-1:0] r;
    s_brtr = {1'b0, br} + {1'b0, tr};
    s_trtl = {1'b0, tr} + {1'b0, tl};
    s_tlbr = {1'b0, tl} + {1'b0, br};
    s_all  = {1'b0, s_brtr} + {1'b0, s_trtl} - {2'b00, tr};
    s_all  = s_all + {2'b00, bl};
    if (bl < br && bl < tr) r = s_brtr[PIX_W:1];
    else if (bl < tr && bl < tl) r = s_trtl[PIX_W:1];
    else if (bl < tl && bl < br) r = s_tlbr[PIX_W:1];
    else r = s_all[PIX_W+1:2];
    return r;
  endfunction

endpackage

// File: src/nsd_front.sv
// ---------------------------------------------------------------------------
// nsd_front: raster position tracking and line store
// Keeps even-row samples in two column banks, holds the bottom-left sample
// and issues one block record per odd column of an odd row.
// ---------------------------------------------------------------------------
module nsd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [nsd_pkg::PIX_W-1:0] sample,
  input  logic                      frame_start,
  input  logic [nsd_pkg::LW_W-1:0]  line_width,
  output logic                      blk_valid,
  output nsd_pkg::quad_t            blk
);

  // even columns in one bank, odd columns in the other: a block reads both
  // at the same pair address
  logic [nsd_pkg::PIX_W-1:0] even_bank [nsd_pkg::BANK_DEPTH];
  logic [nsd_pkg::PIX_W-1:0] odd_bank  [nsd_pkg::BANK_DEPTH];

  logic [nsd_pkg::COL_W-1:0] col;
  logic [nsd_pkg::COL_W-1:0] col_next;
  logic                      odd_row;
  logic                      odd_row_next;
  logic [nsd_pkg::PIX_W-1:0] held_bl;

  logic [nsd_pkg::WW-1:0]      w_raw;
  logic [nsd_pkg::WW-1:0]      w_eff;
  logic [nsd_pkg::COL_W-1:0]   col_cur;
  logic                        odd_cur;
  logic                        last;
  logic [nsd_pkg::BANK_AW-1:0] addr;
  logic                        wr_even;
  logic                        wr_odd;
  logic                        hold;
  logic                        rd;

  always_comb begin
    w_raw = nsd_pkg::WW'({line_width[nsd_pkg::LW_W-1:1], 1'b0});
    if (w_raw < nsd_pkg::WW'(2)) w_eff = nsd_pkg::WW'(2);
    else if (w_raw > nsd_pkg::WW'(nsd_pkg::MAX_LINE_WIDTH))
      w_eff = nsd_pkg::WW'(nsd_pkg::MAX_LINE_WIDTH);
    else w_eff = w_raw;

    col_cur = frame_start ? '0 : col;
    odd_cur = frame_start ? 1'b0 : odd_row;
    last    = (nsd_pkg::WW'(col_cur) + nsd_pkg::WW'(1)) >= w_eff;
    addr    = col_cur[nsd_pkg::COL_W-1:1];

    wr_even = accept && !odd_cur && !col_cur[0];
    wr_odd  = accept && !odd_cur && col_cur[0];
    hold    = accept && odd_cur && !col_cur[0];
    rd      = accept && odd_cur && col_cur[0];

    if (last) begin
      col_next     = '0;
      odd_row_next = ~odd_cur;
    end else begin
      col_next     = col_cur + nsd_pkg::COL_W'(1);
      odd_row_next = odd_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      odd_row   <= 1'b0;
      held_bl   <= '0;
      blk_valid <= 1'b0;
    end else begin
      blk_valid <= rd;
      if (accept) begin
        col     <= col_next;
        odd_row <= odd_row_next;
      end
      if (hold) held_bl <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_even) even_bank[addr] <= sample;
    if (wr_odd) odd_bank[addr] <= sample;
    if (rd) begin
      blk.tl   <= even_bank[addr];
      blk.tr   <= odd_bank[addr];
      blk.bl   <= held_bl;
      blk.br   <= sample;
      blk.last <= last;
    end
  end

endmodule

// File: src/nsd_queue.sv
// ---------------------------------------------------------------------------
// nsd_queue: short block queue between front and back
// Register file with read and write pointers; count feeds the input credit.
// ---------------------------------------------------------------------------
module nsd_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  nsd_pkg::quad_t             push_data,
  input  logic                       take,
  output logic                       head_valid,
  output nsd_pkg::quad_t             head,
  output logic [nsd_pkg::QCNT_W-1:0] count
);

  nsd_pkg::quad_t            entries [nsd_pkg::QDEPTH];
  logic [nsd_pkg::QPTR_W-1:0] wr_ptr;
  logic [nsd_pkg::QPTR_W-1:0] rd_ptr;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + nsd_pkg::QPTR_W'(1);
      if (take) rd_ptr <= rd_ptr + nsd_pkg::QPTR_W'(1);
      case ({push, take})
        2'b10:   count <= count + nsd_pkg::QCNT_W'(1);
        2'b01:   count <= count - nsd_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

// File: src/nsd_back.sv
// ---------------------------------------------------------------------------
// nsd_back: clamp, select and result register
// Takes one block from the queue per cycle while the result slot is free or is popped.
// ---------------------------------------------------------------------------
module nsd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      blk_valid,
  input  nsd_pkg::quad_t            blk,
  input  logic [nsd_pkg::PIX_W-1:0] clamp_low,
  input  logic [nsd_pkg::PIX_W-1:0] clamp_high,
  input  logic                      pop,
  output logic                      take,
  output logic                      res_valid,
  output logic [nsd_pkg::PIX_W-1:0] scaled_sample,
  output logic                      row_end
);

  logic [nsd_pkg::PIX_W-1:0] c_tl;
  logic [nsd_pkg::PIX_W-1:0] c_tr;
  logic [nsd_pkg::PIX_W-1:0] c_bl;
  logic [nsd_pkg::PIX_W-1:0] c_br;
  logic [nsd_pkg::PIX_W-1:0] pick;

  always_comb begin
    c_tl = nsd_pkg::clamp_pix(blk.tl, clamp_low, clamp_high);
    c_tr = nsd_pkg::clamp_pix(blk.tr, clamp_low, clamp_high);
    c_bl = nsd_pkg::clamp_pix(blk.bl, clamp_low, clamp_high);
    c_br = nsd_pkg::clamp_pix(blk.br, clamp_low, clamp_high);
    pick = nsd_pkg::choose_pix(c_bl, c_br, c_tr, c_tl);
  end

  assign take = blk_valid && (!res_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scaled_sample <= pick;
      row_end       <= blk.last;
    end
  end

endmodule

// File: src/neighbor_select_downscale_2x2.sv
// ---------------------------------------------------------------------------
// neighbor_select_downscale_2x2: 2x2 neighbor-select downscaler, 8-bit plane
// Input queue side (push/full) takes one sample per item in raster order;
// result queue side (empty/pop) gives one sample per 2x2 block.
//
// Usage:
// - Input: an item is taken at a clock edge with push high and full low.
//   frame_start marks the first sample of a frame and restarts the position.
// - Results: while empty is low, scaled_sample/row_end show the oldest
//   result; it leaves at an edge with pop high. row_end flags the last
//   result of an output row.
// - Throughput: one input item per cycle, sustained, as long as results are
//   popped as fast as they are made (one per two inputs on odd rows).
// - Path: a block goes from the line store read register into the block queue,
//   then into the result register once the result slot is free or popped.
// - Stall: with pop low the result register holds, the four-entry block
//   queue fills, and full rises once queued plus in-flight blocks reach four.
// - Reset (rst, synchronous): position, queue and result slot clear; config
//   returns to width 720, clamp 16..240. Line store contents are not cleared.
// - Config: write_enable/reg_index/write_data, for use only while idle (not enforced by the block).
// ---------------------------------------------------------------------------
module neighbor_select_downscale_2x2 (
  input  logic                          clk,
  input  logic                          rst,
  // input side
  input  logic                          push,
  output logic                          full,
  input  logic [nsd_pkg::PIX_W-1:0]     sample,
  input  logic                          frame_start,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic [nsd_pkg::PIX_W-1:0]     scaled_sample,
  output logic                          row_end,
  // config writes
  input  logic                          write_enable,
  input  logic [nsd_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [nsd_pkg::CFG_W-1:0]     write_data
);

  logic [nsd_pkg::LW_W-1:0]  line_width;
  logic [nsd_pkg::PIX_W-1:0] clamp_low;
  logic [nsd_pkg::PIX_W-1:0] clamp_high;

  logic                       accept;
  logic                       fe_valid;
  nsd_pkg::quad_t             fe_blk;
  logic                       q_valid;
  nsd_pkg::quad_t             q_head;
  logic [nsd_pkg::QCNT_W-1:0] q_count;
  logic                       q_take;
  logic                       res_valid;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= nsd_pkg::LINE_WIDTH_RST;
      clamp_low  <= nsd_pkg::CLAMP_LOW_RST;
      clamp_high <= nsd_pkg::CLAMP_HIGH_RST;
    end else if (write_enable) begin
      unique case (nsd_pkg::reg_idx_t'(reg_index))
        nsd_pkg::REG_LINE_WIDTH: line_width <= write_data[nsd_pkg::LW_W-1:0];
        nsd_pkg::REG_CLAMP_LOW:  clamp_low  <= write_data[nsd_pkg::PIX_W-1:0];
        nsd_pkg::REG_CLAMP_HIGH: clamp_high <= write_data[nsd_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // credit: a block in the read stage already owns a queue slot
  assign full   = rst || ((q_count + nsd_pkg::QCNT_W'(fe_valid))
                          >= nsd_pkg::QCNT_W'(nsd_pkg::QDEPTH));
  assign accept = push && !full;
  assign empty  = !res_valid;

  nsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sample      (sample),
    .frame_start (frame_start),
    .line_width  (line_width),
    .blk_valid   (fe_valid),
    .blk         (fe_blk)
  );

  nsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fe_valid),
    .push_data  (fe_blk),
    .take       (q_take),
    .head_valid (q_valid),
    .head       (q_head),
    .count      (q_count)
  );

  nsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .blk_valid     (q_valid),
    .blk           (q_head),
    .clamp_low     (clamp_low),
    .clamp_high    (clamp_high),
    .pop           (pop),
    .take          (q_take),
    .res_valid     (res_valid),
    .scaled_sample (scaled_sample),
    .row_end       (row_end)
  );

  // queue plus read stage never exceeds the queue depth
  assert property (@(posedge clk) disable iff (rst)
    (nsd_pkg::QCNT_W'(q_count + nsd_pkg::QCNT_W'(fe_valid))
     <= nsd_pkg::QCNT_W'(nsd_pkg::QDEPTH)))
    else $error("block queue overcommitted");

  // a block in the read stage comes from an item taken in the cycle before
  assert property (@(posedge clk) disable iff (rst)
    fe_valid |-> $past(accept))
    else $error("block issued without an input item");

  // back end only takes from a non-empty queue
  assert property (@(posedge clk) disable iff (rst)
    q_take |-> (q_count != '0))
    else $error("take from empty block queue");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench of the 2x2 neighbor-select downscaler
// Streams raster samples through the input queue side and checks every
// result against an in-bench predictor of the block. The run covers each
// selection branch, crossed and full clamp ranges, degenerate, odd and
// oversized line widths, a width lowered in the middle of a row, restarts in
// mid frame, and random frames with random idling on both sides.
// ---------------------------------------------------------------------------
module tb;

  localparam int DRAIN_TAIL  = 8;     // room for the pipeline to empty, leave margin
  localparam int QUIET_LIMIT = 1000;  // cycles with no handshake at all
  localparam int IDLE_PCT    = 19;

  // one expected result of a 2x2 block
  typedef struct packed {
    logic [nsd_pkg::PIX_W-1:0] pix;
    logic                      last;
  } block_result_t;

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          push         = 1'b0;
  logic                          full;
  logic [nsd_pkg::PIX_W-1:0]     sample       = '0;
  logic                          frame_start  = 1'b0;
  logic                          empty;
  logic                          pop          = 1'b0;
  logic [nsd_pkg::PIX_W-1:0]     scaled_sample;
  logic                          row_end;
  logic                          write_enable = 1'b0;
  logic [nsd_pkg::REG_IDX_W-1:0] reg_index    = nsd_pkg::REG_LINE_WIDTH;
  logic [nsd_pkg::CFG_W-1:0]     write_data   = '0;

  neighbor_select_downscale_2x2 uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .frame_start  (frame_start),
    .empty        (empty),
    .pop          (pop),
    .scaled_sample(scaled_sample),
    .row_end      (row_end),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor state: config copy, line store with a written flag per entry,
  // raster position and the held bottom-left sample.
  // -------------------------------------------------------------------------
  logic [nsd_pkg::LW_W-1:0]  width_cfg = nsd_pkg::LINE_WIDTH_RST;
  logic [nsd_pkg::PIX_W-1:0] clamp_lo  = nsd_pkg::CLAMP_LOW_RST;
  logic [nsd_pkg::PIX_W-1:0] clamp_hi  = nsd_pkg::CLAMP_HIGH_RST;
  logic [nsd_pkg::PIX_W-1:0] top_line    [nsd_pkg::MAX_LINE_WIDTH];
  bit                        top_written [nsd_pkg::MAX_LINE_WIDTH];
  int unsigned               col_pos   = 0;
  bit                        lower_row = 1'b0;
  logic [nsd_pkg::PIX_W-1:0] held_left = '0;

  block_result_t expected_blocks[$];
  int            errors      = 0;
  bit            steady_flow = 1'b0;  // when set, neither side idles
  int unsigned   quiet       = 0;

  // width in use: even, at least 2, at most the store depth
  function automatic int unsigned active_width();
    int unsigned w;
    w = width_cfg & 11'h7FE;
    if (w < 2) w = 2;
    if (w > nsd_pkg::MAX_LINE_WIDTH) w = nsd_pkg::MAX_LINE_WIDTH;
    return w;
  endfunction

  // crossed limits: values below the low limit take it, all others the high limit
  function automatic int clip_to_limits(input logic [nsd_pkg::PIX_W-1:0] v);
    if (v < clamp_lo) return clamp_lo;
    if (v > clamp_hi) return clamp_hi;
    return v;
  endfunction

  function automatic logic [nsd_pkg::PIX_W-1:0] pick_block_value(
    input int bl, input int br, input int tr, input int tl);
    int v;
    if (bl < br && bl < tr) v = (br + tr) / 2;
    else if (bl < tr && bl < tl) v = (tr + tl) / 2;
    else if (bl < tl && bl < br) v = (tl + br) / 2;
    else v = (bl + br + tr + tl) / 4;
    return nsd_pkg::PIX_W'(v);
  endfunction

  // would this item read a line store entry never written since reset
  function automatic bit reads_unwritten(input logic fs);
    int unsigned col;
    col = (col_pos >= nsd_pkg::MAX_LINE_WIDTH) ? 0 : col_pos;
    return !fs && lower_row && (col % 2 == 1) &&
           !(top_written[col-1] && top_written[col]);
  endfunction

  // advance the predictor by one accepted sample
  function automatic void downscale_sample(input logic [nsd_pkg::PIX_W-1:0] s,
                                           input logic fs);
    int unsigned   w;
    int unsigned   col;
    bit            last;
    block_result_t r;
    w = active_width();
    if (fs) begin
      col_pos   = 0;
      lower_row = 1'b0;
    end
    col  = (col_pos >= nsd_pkg::MAX_LINE_WIDTH) ? 0 : col_pos;
    last = (col + 1 >= w);
    if (!lower_row) begin
      top_line[col]    = s;
      top_written[col] = 1'b1;
    end else if (col % 2 == 0) begin
      held_left = s;
    end else begin
      r.pix  = pick_block_value(clip_to_limits(held_left), clip_to_limits(s),
                                clip_to_limits(top_line[col]),
                                clip_to_limits(top_line[col-1]));
      r.last = last;
      expected_blocks.push_back(r);
    end
    if (last) begin
      col_pos   = 0;
      lower_row = !lower_row;
    end else begin
      col_pos = col + 1;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Input side. push stays high from one item to the next; it only drops in
  // an idle cycle or when the stream is drained.
  // -------------------------------------------------------------------------
  task automatic push_item(input logic [nsd_pkg::PIX_W-1:0] s, input logic fs);
    logic fs_used;
    // restart the frame rather than read a never-written store entry
    fs_used = fs | reads_unwritten(fs);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    sample      <= s;
    frame_start <= fs_used;
    @(posedge clk);
    while (full) @(posedge clk);
    downscale_sample(s, fs_used);
  endtask

  // stop the stream and let every block leave the pipeline
  task automatic drain();
    push <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // writes all three registers, one per cycle; only called when drained
  task automatic set_config(input int unsigned w, input logic [nsd_pkg::PIX_W-1:0] lo,
                            input logic [nsd_pkg::PIX_W-1:0] hi);
    write_enable <= 1'b1;
    reg_index    <= nsd_pkg::REG_LINE_WIDTH;
    write_data   <= nsd_pkg::CFG_W'(w);
    @(posedge clk);
    reg_index    <= nsd_pkg::REG_CLAMP_LOW;
    write_data   <= nsd_pkg::CFG_W'(lo);
    @(posedge clk);
    reg_index    <= nsd_pkg::REG_CLAMP_HIGH;
    write_data   <= nsd_pkg::CFG_W'(hi);
    @(posedge clk);
    write_enable <= 1'b0;
    width_cfg = nsd_pkg::LW_W'(w);
    clamp_lo  = lo;
    clamp_hi  = hi;
  endtask

  // extremes show up often on purpose
  function automatic logic [nsd_pkg::PIX_W-1:0] random_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return nsd_pkg::PIX_W'($urandom());
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Result side: check each popped result against the oldest expected block.
  // -------------------------------------------------------------------------
  task automatic check_result();
    block_result_t want;
    if (expected_blocks.size() == 0) begin
      $error("unexpected result: scaled_sample=%0d row_end=%0b", scaled_sample, row_end);
      errors++;
    end else begin
      want = expected_blocks.pop_front();
      if (scaled_sample !== want.pix) begin
        $error("scaled_sample: expected %0d, actual %0d", want.pix, scaled_sample);
        errors++;
      end
      if (row_end !== want.last) begin
        $error("row_end: expected %0b, actual %0b", want.last, row_end);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (pop && !empty) check_result();
    pop <= !rst && (steady_flow || $urandom_range(99) >= IDLE_PCT);
  end

  // watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // one block per selection branch, sample extremes 0 and 255, full range
  task automatic test_select_branches();
    drain();
    set_config(4, 8'd0, 8'd255);
    // top row: (TL,TR) = (10,200) (255,128)
    push_item(8'd10, 1'b1);
    push_item(8'd200, 1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd128, 1'b0);
    // bottom row: BL below BR and TR; BL below TR and TL only
    push_item(8'd5, 1'b0);
    push_item(8'd100, 1'b0);
    push_item(8'd50, 1'b0);
    push_item(8'd0, 1'b0);
    // top row: (TL,TR) = (200,0) (1,2)
    push_item(8'd200, 1'b0);
    push_item(8'd0, 1'b0);
    push_item(8'd1, 1'b0);
    push_item(8'd2, 1'b0);
    // bottom row: BL below TL and BR only; BL largest, mean of four
    push_item(8'd100, 1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd255, 1'b0);
    push_item(8'd3, 1'b0);
  endtask

  // low limit above high limit; odd width rounds down to 2
  task automatic test_crossed_limits();
    drain();
    set_config(3, 8'd200, 8'd50);
    push_item(8'd0, 1'b1);
    push_item(8'd255, 1'b0);
    push_item(8'd100, 1'b0);
    push_item(8'd220, 1'b0);
  endtask

  // huge width, then width 0 (raised to 2) while in the middle of a row
  task automatic test_width_lowered_mid_row();
    drain();
    set_config(2047, 8'd255, 8'd0);
    push_item(8'd7, 1'b1);
    push_item(8'd255, 1'b0);
    push_item(8'd9, 1'b0);
    push_item(8'd128, 1'b0);
    drain();
    set_config(0, 8'd255, 8'd0);
    push_item(8'd33, 1'b0);   // column 4 now closes the top row
    push_item(8'd255, 1'b0);
    push_item(8'd1, 1'b0);
  endtask

  // random frames under changing configs; mostly whole rows, some noise
  task automatic test_random_frames();
    int unsigned               sent;
    int unsigned               w;
    int unsigned               rows;
    int unsigned               extra;
    logic [nsd_pkg::PIX_W-1:0] lo;
    logic [nsd_pkg::PIX_W-1:0] hi;
    logic                      fs;
    sent = 0;
    for (int phase = 0; sent < 410; phase++) begin
      case ($urandom_range(7))
        0: w = $urandom_range(0, 1);
        1: w = $urandom_range(17, 80);
        2: w = 2 * $urandom_range(1, 8) + 1;
        default: w = 2 * $urandom_range(1, 8);
      endcase
      case ($urandom_range(4))
        0: begin lo = 8'd0;  hi = 8'd255; end
        1: begin lo = 8'd16; hi = 8'd235; end
        2: begin
          lo = nsd_pkg::PIX_W'($urandom_range(0, 127));
          hi = nsd_pkg::PIX_W'($urandom_range(128, 255));
        end
        default: begin
          lo = nsd_pkg::PIX_W'($urandom());
          hi = nsd_pkg::PIX_W'($urandom());
        end
      endcase
      // one long stretch with no idling on either side
      if (phase == 1) w = 64;
      drain();
      steady_flow = (phase == 1);
      set_config(w, lo, hi);
      w    = active_width();
      rows = (w > 16) ? 2 : 2 * $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < w; c++) begin
          // the first item sometimes carries on from where the last phase stopped
          if (r == 0 && c == 0) fs = ($urandom_range(3) != 0);
          else fs = ($urandom_range(99) < 2);
          push_item(random_sample(), fs);
          sent++;
        end
      end
      // broken row left behind for the next phase
      if ($urandom_range(9) < 4) begin
        extra = (w > 2) ? $urandom_range(1, w - 1) : 1;
        repeat (extra) begin
          push_item(random_sample(), 1'b0);
          sent++;
        end
      end
    end
    drain();
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_select_branches();
    test_crossed_limits();
    test_width_lowered_mid_row();
    test_random_frames();
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/nsd_pkg.sv
src/nsd_front.sv
src/nsd_queue.sv
src/nsd_back.sv
src/neighbor_select_downscale_2x2.sv
dv/tb.sv
